[rtl/kmoi_pkg.sv]
// Package with the transaction types and codes of the keyed map with ordered iteration.
package kmoi_pkg;

  localparam logic [2:0] REQ_INSERT  = 3'd0;
  localparam logic [2:0] REQ_DELETE  = 3'd1;
  localparam logic [2:0] REQ_LOOKUP  = 3'd2;
  localparam logic [2:0] REQ_RESTART = 3'd3;
  localparam logic [2:0] REQ_NEXT    = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_DUP     = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_NONE    = 3'd4;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] key;
    logic [31:0]        value;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] out_key;
    logic [31:0]        out_value;
  } rsp_t;

endpackage

[rtl/keyed_map_with_ordered_iteration.sv]
// Top level of the keyed map with ordered iteration: a chained hash map in a node memory.
//
// After reset the block clears its bucket head memory, one bucket a cycle, and takes no
// transaction meanwhile. It then serves one request at a time. A request's time is set by
// the bucket chain walk in the node memory: lookup and delete walk the chain, insert walks
// it and then links the new node into the chain and the order list, delete then unlinks
// the node from both and frees it; restart and iterator next need no walk. A new request
// is taken while the previous result still waits in the output register.
module keyed_map_with_ordered_iteration #(
  parameter int NUM_BUCKETS = 64,
  parameter int POOL_SIZE   = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  kmoi_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output kmoi_pkg::rsp_t rsp
);
  import kmoi_pkg::*;

  localparam int IW  = $clog2(POOL_SIZE + 1);
  localparam int NAW = $clog2(POOL_SIZE);
  localparam int BAW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam logic [IW-1:0]  NIL   = IW'(POOL_SIZE);
  localparam logic [BAW-1:0] BMASK = BAW'(NUM_BUCKETS - 1);

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_DISP  = 5'd2;
  localparam logic [4:0] S_BHW   = 5'd3;
  localparam logic [4:0] S_WALK  = 5'd4;
  localparam logic [4:0] S_DEC   = 5'd5;
  localparam logic [4:0] S_ALLOC = 5'd6;
  localparam logic [4:0] S_LINK  = 5'd7;
  localparam logic [4:0] S_TRD   = 5'd8;
  localparam logic [4:0] S_TWR   = 5'd9;
  localparam logic [4:0] S_NWR   = 5'd10;
  localparam logic [4:0] S_DCH   = 5'd11;
  localparam logic [4:0] S_DPR   = 5'd12;
  localparam logic [4:0] S_DPW   = 5'd13;
  localparam logic [4:0] S_DQR   = 5'd14;
  localparam logic [4:0] S_DQW   = 5'd15;
  localparam logic [4:0] S_DFREE = 5'd16;
  localparam logic [4:0] S_IRW   = 5'd17;
  localparam logic [4:0] S_DONE  = 5'd18;

  typedef struct packed {
    logic [31:0]   key;
    logic [31:0]   value;
    logic [IW-1:0] chain_next;
    logic [IW-1:0] order_next;
    logic [IW-1:0] order_prev;
  } node_t;

  node_t          node_mem [POOL_SIZE];
  logic [IW-1:0]  bucket_mem [NUM_BUCKETS];
  logic [NAW-1:0] free_mem [POOL_SIZE];

  node_t          node_q;
  logic [IW-1:0]  bucket_q;
  logic [NAW-1:0] free_q;

  logic [4:0]     state, state_next;
  logic [BAW-1:0] clr_idx, clr_idx_next;
  logic [2:0]     req_type, req_type_next;
  logic [31:0]    key, key_next;
  logic [31:0]    value, value_next;
  logic [IW-1:0]  cur, cur_next;
  logic [IW-1:0]  prev, prev_next;
  logic [IW-1:0]  steps, steps_next;
  logic [IW-1:0]  node, node_next;
  logic           found, found_next;
  node_t          prec, prec_next;
  node_t          nrec, nrec_next;
  logic [IW-1:0]  free_top, free_top_next;
  logic [IW-1:0]  fresh_count, fresh_count_next;
  logic [IW-1:0]  order_head, order_head_next;
  logic [IW-1:0]  order_tail, order_tail_next;
  logic [IW-1:0]  iter_cursor, iter_cursor_next;
  logic [IW-1:0]  entry_count, entry_count_next;
  rsp_t           res, res_next;

  logic           nwr_en;
  logic [IW-1:0]  nwr_idx;
  node_t          nwr_data;
  logic [IW-1:0]  nrd_idx;
  logic           bwr_en;
  logic [BAW-1:0] bwr_addr;
  logic [IW-1:0]  bwr_data;
  logic           fwr_en;
  logic [IW-1:0]  frd_idx;

  logic [BAW-1:0] bidx;
  logic [IW-1:0]  steps_inc;
  node_t          new_node;

  assign bidx      = key[BAW-1:0] & BMASK;
  assign steps_inc = steps + IW'(1);
  assign req_stall = (state != S_IDLE);

  always_comb begin
    new_node            = '0;
    new_node.key        = key;
    new_node.value      = value;
    new_node.chain_next = NIL;
    new_node.order_next = NIL;
    new_node.order_prev = order_tail;
  end

  always_ff @(posedge clk) begin
    if (nwr_en) begin
      node_mem[nwr_idx[NAW-1:0]] <= nwr_data;
    end
    node_q <= node_mem[nrd_idx[NAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (bwr_en) begin
      bucket_mem[bwr_addr] <= bwr_data;
    end
    bucket_q <= bucket_mem[bidx];
  end

  always_ff @(posedge clk) begin
    if (fwr_en) begin
      free_mem[free_top[NAW-1:0]] <= node[NAW-1:0];
    end
    free_q <= free_mem[frd_idx[NAW-1:0]];
  end

  always_comb begin
    state_next       = state;
    clr_idx_next     = clr_idx;
    req_type_next    = req_type;
    key_next         = key;
    value_next       = value;
    cur_next         = cur;
    prev_next        = prev;
    steps_next       = steps;
    node_next        = node;
    found_next       = found;
    prec_next        = prec;
    nrec_next        = nrec;
    free_top_next    = free_top;
    fresh_count_next = fresh_count;
    order_head_next  = order_head;
    order_tail_next  = order_tail;
    iter_cursor_next = iter_cursor;
    entry_count_next = entry_count;
    res_next         = res;
    nwr_en           = 1'b0;
    nwr_idx          = node;
    nwr_data         = node_q;
    nrd_idx          = cur;
    bwr_en           = 1'b0;
    bwr_addr         = bidx;
    bwr_data         = node;
    fwr_en           = 1'b0;
    frd_idx          = free_top - IW'(1);

    unique case (state)
      S_CLR: begin
        bwr_en       = 1'b1;
        bwr_addr     = clr_idx;
        bwr_data     = NIL;
        clr_idx_next = clr_idx + BAW'(1);
        if (clr_idx == BMASK) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          req_type_next = req.req_type;
          key_next      = req.key;
          value_next    = req.value;
          state_next    = S_DISP;
        end
      end
      S_DISP: begin
        res_next = '{status: ST_INVALID, out_key: -32'sd1, out_value: 32'd0};
        nrd_idx  = iter_cursor;
        case (req_type)
          REQ_INSERT: begin
            state_next = (key[31] || value == 32'd0) ? S_DONE : S_BHW;
          end
          REQ_DELETE, REQ_LOOKUP: begin
            state_next = key[31] ? S_DONE : S_BHW;
          end
          REQ_RESTART: begin
            iter_cursor_next = order_head;
            res_next.status  = ST_OK;
            state_next       = S_DONE;
          end
          REQ_NEXT: begin
            if (iter_cursor == NIL) begin
              res_next.status = ST_NONE;
              state_next      = S_DONE;
            end else begin
              state_next = S_IRW;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_BHW: begin
        prev_next  = NIL;
        steps_next = '0;
        found_next = 1'b0;
        cur_next   = bucket_q;
        nrd_idx    = bucket_q;
        state_next = (bucket_q == NIL) ? S_DEC : S_WALK;
      end
      S_WALK: begin
        if (node_q.key == key) begin
          found_next = 1'b1;
          node_next  = cur;
          nrec_next  = node_q;
          state_next = S_DEC;
        end else begin
          prev_next  = cur;
          prec_next  = node_q;
          steps_next = steps_inc;
          cur_next   = node_q.chain_next;
          nrd_idx    = node_q.chain_next;
          if (node_q.chain_next == NIL || steps_inc == NIL) begin
            state_next = S_DEC;
          end
        end
      end
      S_DEC: begin
        if (req_type == REQ_INSERT) begin
          if (found) begin
            res_next.status = ST_DUP;
            state_next      = S_DONE;
          end else if (free_top != '0) begin
            state_next = S_ALLOC;
          end else if (fresh_count != NIL) begin
            node_next        = fresh_count;
            fresh_count_next = fresh_count + IW'(1);
            state_next       = S_LINK;
          end else begin
            res_next.status = ST_FULL;
            state_next      = S_DONE;
          end
        end else if (!found) begin
          res_next.status = ST_NONE;
          state_next      = S_DONE;
        end else begin
          res_next   = '{status: ST_OK, out_key: nrec.key, out_value: nrec.value};
          state_next = (req_type == REQ_DELETE) ? S_DCH : S_DONE;
        end
      end
      S_ALLOC: begin
        node_next     = IW'(free_q);
        free_top_next = free_top - IW'(1);
        state_next    = S_LINK;
      end
      S_LINK: begin
        if (prev != NIL) begin
          nwr_en              = 1'b1;
          nwr_idx             = prev;
          nwr_data            = prec;
          nwr_data.chain_next = node;
        end else begin
          bwr_en = 1'b1;
        end
        state_next = S_TRD;
      end
      S_TRD: begin
        nrd_idx = order_tail;
        if (order_tail != NIL) begin
          state_next = S_TWR;
        end else begin
          order_head_next = node;
          state_next      = S_NWR;
        end
      end
      S_TWR: begin
        nwr_en              = 1'b1;
        nwr_idx             = order_tail;
        nwr_data            = node_q;
        nwr_data.order_next = node;
        state_next          = S_NWR;
      end
      S_NWR: begin
        nwr_en           = 1'b1;
        nwr_data         = new_node;
        order_tail_next  = node;
        entry_count_next = entry_count + IW'(1);
        res_next         = '{status: ST_OK, out_key: key, out_value: value};
        state_next       = S_DONE;
      end
      S_DCH: begin
        if (prev != NIL) begin
          nwr_en              = 1'b1;
          nwr_idx             = prev;
          nwr_data            = prec;
          nwr_data.chain_next = nrec.chain_next;
        end else begin
          bwr_en   = 1'b1;
          bwr_data = nrec.chain_next;
        end
        if (iter_cursor == node) begin
          iter_cursor_next = nrec.order_next;
        end
        state_next = S_DPR;
      end
      S_DPR: begin
        nrd_idx = nrec.order_prev;
        if (nrec.order_prev != NIL) begin
          state_next = S_DPW;
        end else begin
          order_head_next = nrec.order_next;
          state_next      = S_DQR;
        end
      end
      S_DPW: begin
        nwr_en              = 1'b1;
        nwr_idx             = nrec.order_prev;
        nwr_data            = node_q;
        nwr_data.order_next = nrec.order_next;
        state_next          = S_DQR;
      end
      S_DQR: begin
        nrd_idx = nrec.order_next;
        if (nrec.order_next != NIL) begin
          state_next = S_DQW;
        end else begin
          order_tail_next = nrec.order_prev;
          state_next      = S_DFREE;
        end
      end
      S_DQW: begin
        nwr_en              = 1'b1;
        nwr_idx             = nrec.order_next;
        nwr_data            = node_q;
        nwr_data.order_prev = nrec.order_prev;
        state_next          = S_DFREE;
      end
      S_DFREE: begin
        if (free_top != NIL) begin
          fwr_en        = 1'b1;
          free_top_next = free_top + IW'(1);
        end
        if (entry_count != '0) begin
          entry_count_next = entry_count - IW'(1);
        end
        state_next = S_DONE;
      end
      S_IRW: begin
        res_next         = '{status: ST_OK, out_key: node_q.key, out_value: node_q.value};
        iter_cursor_next = node_q.order_next;
        state_next       = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      clr_idx     <= '0;
      free_top    <= '0;
      fresh_count <= '0;
      order_head  <= NIL;
      order_tail  <= NIL;
      iter_cursor <= NIL;
      entry_count <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      clr_idx     <= clr_idx_next;
      free_top    <= free_top_next;
      fresh_count <= fresh_count_next;
      order_head  <= order_head_next;
      order_tail  <= order_tail_next;
      iter_cursor <= iter_cursor_next;
      entry_count <= entry_count_next;
      if (state == S_DONE && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_type <= req_type_next;
    key      <= key_next;
    value    <= value_next;
    cur      <= cur_next;
    prev     <= prev_next;
    steps    <= steps_next;
    node     <= node_next;
    found    <= found_next;
    prec     <= prec_next;
    nrec     <= nrec_next;
    res      <= res_next;
    if (state == S_DONE && (!rsp_valid || !rsp_stall)) begin
      rsp <= res;
    end
  end

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the keyed map with ordered iteration block.
`timescale 1ns / 1ps

module tb_top;
  import kmoi_pkg::*;

  localparam int NUM_BUCKETS = 64;
  localparam int POOL_SIZE   = 256;
  localparam int NIL         = POOL_SIZE;
  localparam int WATCHDOG    = 20000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  keyed_map_with_ordered_iteration #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .POOL_SIZE(POOL_SIZE)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  // Shadow copy of the map.
  int bucket_head [NUM_BUCKETS];
  logic [31:0] node_key [POOL_SIZE];
  logic [31:0] node_val [POOL_SIZE];
  int chain_next [POOL_SIZE];
  int order_next [POOL_SIZE];
  int order_prev [POOL_SIZE];
  int free_stack [POOL_SIZE];
  int free_top, fresh_count, order_head, order_tail, cursor, entry_count;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int idle_pct, stall_pct;
  int errors;
  int quiet_cycles;
  logic hold_off;
  logic stim_done;

  function automatic int find_node(logic [31:0] k, output int prev);
    int p, cur, steps;
    p = NIL;
    cur = bucket_head[k % NUM_BUCKETS];
    steps = 0;
    while (cur < NIL && steps < POOL_SIZE) begin
      if (node_key[cur] == k) begin
        prev = p;
        return cur;
      end
      p = cur;
      cur = chain_next[cur];
      steps++;
    end
    prev = p;
    return NIL;
  endfunction

  function automatic rsp_t map_update(req_t r);
    rsp_t o;
    int n, prev, p, q;
    logic [31:0] k;
    k = r.key;
    o.status = ST_INVALID;
    o.out_key = -1;
    o.out_value = '0;
    case (r.req_type)
      REQ_INSERT: begin
        if (k[31] || r.value == 0) return o;
        n = find_node(k, prev);
        if (n < NIL) begin
          o.status = ST_DUP;
          return o;
        end
        if (free_top > 0 && free_stack[free_top - 1] < NIL) begin
          free_top--;
          n = free_stack[free_top];
        end else if (fresh_count < POOL_SIZE) begin
          n = fresh_count;
          fresh_count++;
        end else begin
          o.status = ST_FULL;
          return o;
        end
        node_key[n] = k;
        node_val[n] = r.value;
        chain_next[n] = NIL;
        if (prev < NIL) chain_next[prev] = n;
        else bucket_head[k % NUM_BUCKETS] = n;
        order_prev[n] = order_tail;
        order_next[n] = NIL;
        if (order_tail < NIL) order_next[order_tail] = n;
        else order_head = n;
        order_tail = n;
        entry_count++;
        o.status = ST_OK;
        o.out_key = k;
        o.out_value = r.value;
      end
      REQ_DELETE, REQ_LOOKUP: begin
        if (k[31]) return o;
        n = find_node(k, prev);
        if (n >= NIL) begin
          o.status = ST_NONE;
          return o;
        end
        o.status = ST_OK;
        o.out_key = node_key[n];
        o.out_value = node_val[n];
        if (r.req_type == REQ_DELETE) begin
          p = order_prev[n];
          q = order_next[n];
          if (prev < NIL) chain_next[prev] = chain_next[n];
          else bucket_head[k % NUM_BUCKETS] = chain_next[n];
          if (cursor == n) cursor = q;
          if (p < NIL) order_next[p] = q;
          else order_head = q;
          if (q < NIL) order_prev[q] = p;
          else order_tail = p;
          if (free_top < POOL_SIZE) begin
            free_stack[free_top] = n;
            free_top++;
          end
          if (entry_count > 0) entry_count--;
        end
      end
      REQ_RESTART: begin
        cursor = order_head;
        o.status = ST_OK;
      end
      REQ_NEXT: begin
        n = cursor;
        if (n >= NIL) begin
          o.status = ST_NONE;
          return o;
        end
        o.status = ST_OK;
        o.out_key = node_key[n];
        o.out_value = node_val[n];
        cursor = order_next[n];
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic add_req(logic [2:0] t, logic [31:0] k, logic [31:0] v);
    req_t r;
    r.req_type = t;
    r.key = k;
    r.value = v;
    pending_reqs.push_back(r);
  endtask

  // Keys mostly from a small set, spread across a few buckets to build chains.
  function automatic logic [31:0] pick_key(int span);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 85) return ($urandom_range(0, span - 1) * 16) + $urandom_range(0, 3);
    if (sel < 93) return $urandom & 32'h7fff_ffff;
    return $urandom | 32'h8000_0000;
  endfunction

  task automatic add_random(int count, int span, int ins_weight);
    int sel;
    logic [31:0] v;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      v = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom;
      if (sel < ins_weight) add_req(REQ_INSERT, pick_key(span), v);
      else if (sel < ins_weight + 20) add_req(REQ_DELETE, pick_key(span), v);
      else if (sel < ins_weight + 35) add_req(REQ_LOOKUP, pick_key(span), v);
      else if (sel < ins_weight + 40) add_req(REQ_RESTART, $urandom, $urandom);
      else if (sel < 98) add_req(REQ_NEXT, $urandom, $urandom);
      else add_req(3'($urandom_range(5, 7)), $urandom, $urandom);
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < NUM_BUCKETS; i++) bucket_head[i] = NIL;
    free_top = 0;
    fresh_count = 0;
    order_head = NIL;
    order_tail = NIL;
    cursor = NIL;
    entry_count = 0;
    errors = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_off = 1'b0;
    stim_done = 1'b0;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    add_req(REQ_NEXT, 0, 0);
    add_req(REQ_LOOKUP, 0, 0);
    add_req(REQ_DELETE, 5, 0);
    add_req(REQ_INSERT, 0, 32'hffff_ffff);
    add_req(REQ_INSERT, 32'h7fff_ffff, 1);
    add_req(REQ_INSERT, 64, 32'h8000_0000);
    add_req(REQ_INSERT, 128, 7);
    add_req(REQ_INSERT, 64, 9);
    add_req(REQ_INSERT, 32'h8000_0000, 5);
    add_req(REQ_INSERT, 3, 0);
    add_req(REQ_LOOKUP, 128, 0);
    add_req(REQ_LOOKUP, 32'hffff_ffff, 0);
    add_req(REQ_LOOKUP, 192, 0);
    add_req(REQ_RESTART, 0, 0);
    add_req(REQ_NEXT, 0, 0);
    add_req(REQ_DELETE, 64, 0);
    add_req(REQ_NEXT, 0, 0);
    add_req(REQ_DELETE, 32'h8000_0001, 0);
    add_req(REQ_NEXT, 0, 0);
    add_req(REQ_NEXT, 0, 0);
    add_req(3'd5, 1, 1);
    add_req(3'd7, 32'hffff_ffff, 32'hffff_ffff);
    add_req(REQ_INSERT, 64, 11);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 73 : (ph == 3 ? 11 : 0);
      stall_pct = (ph == 2) ? 73 : (ph == 3 ? 11 : 0);
      add_random(250, 24, 45);
      wait_drained();
    end

    // Fill the pool to full, then empty it again through deletes.
    idle_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < POOL_SIZE + 4; i++) add_req(REQ_INSERT, 1000 + i * 3, $urandom | 1);
    add_req(REQ_RESTART, 0, 0);
    for (int i = 0; i < 20; i++) add_req(REQ_NEXT, 0, 0);
    for (int i = 0; i < POOL_SIZE + 4; i++) begin
      add_req(REQ_DELETE, 1000 + i * 3, 0);
      if (i % 10 == 0) add_req(REQ_NEXT, 0, 0);
    end
    wait_drained();

    hold_off = 1'b1;
    repeat (20) @(posedge clk);
    hold_off = 1'b0;
    idle_pct = 30;
    stall_pct = 30;
    add_random(200, 40, 60);
    wait_drained();
    stim_done = 1'b1;
  end

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req <= '0;
      rsp_stall <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        expected_rsps.push_back(map_update(req));
        void'(pending_reqs.pop_front());
      end
      if (!(req_valid && req_stall)) begin
        if (pending_reqs.size() > (req_valid && !req_stall ? 0 : 0) && !hold_off &&
            $urandom_range(0, 99) >= idle_pct) begin
          req_valid <= 1'b1;
          req <= pending_reqs[0];
        end else begin
          req_valid <= 1'b0;
        end
      end
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected transaction: status %0d key %0d value %0h",
               rsp.status, rsp.out_key, rsp.out_value);
        errors++;
      end else begin
        rsp_t e;
        e = expected_rsps.pop_front();
        if (rsp.status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, rsp.status);
          errors++;
        end
        if (rsp.out_key !== e.out_key) begin
          $error("out_key: expected %0d, actual %0d", e.out_key, rsp.out_key);
          errors++;
        end
        if (rsp.out_value !== e.out_value) begin
          $error("out_value: expected %0h, actual %0h", e.out_value, rsp.out_value);
          errors++;
        end
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (stim_done) begin
        repeat (50) @(posedge clk);
        if (errors == 0 && expected_rsps.size() == 0) $display("tb_top: done, clean");
        else $display("tb_top: done, errors");
        $finish;
      end else if (quiet_cycles >= WATCHDOG) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

endmodule
